// ===== src/ttm_pkg.sv =====
// Shared types, codes and constants of the tunnel texture mapper.
`default_nettype none
package ttm_pkg;

    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_FRAME = 2'd1,
        OP_WRITE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        CFG_CENTRE_X      = 3'd0,
        CFG_CENTRE_Y      = 3'd1,
        CFG_HOLE_RADIUS   = 3'd2,
        CFG_DEPTH_GAIN    = 3'd3,
        CFG_ANGLE_GAIN    = 3'd4,
        CFG_ZOOM_STEP     = 3'd5,
        CFG_ROTATION_STEP = 3'd6
    } t_cfg_idx;

    localparam int NUM_SQ   = 16;   // log fraction bits, also CORDIC steps
    localparam int DIV_BITS = 25;   // quotient bits of the depth term
    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic signed [17:0] HALF_TURN = 18'sd32768;

    // Work item passed from the front end to the datapath.
    typedef struct packed {
        logic               wr;
        logic signed [10:0] dx;
        logic signed [10:0] dy;
        logic [15:0]        zoom;
        logic [15:0]        rot;
        logic [15:0]        tidx;
        logic [7:0]         tval;
    } t_item;

    // Static configuration seen by the datapath.
    typedef struct packed {
        logic [19:0] r2;
        logic [15:0] depth_gain;
        logic [11:0] angle_gain;
    } t_cfg;

    // Arctangent of 2^-i in binary angle units, half turn = 32768.
    function automatic logic signed [17:0] atan_unit(input int i);
        logic signed [17:0] r;
        case (i)
            0:       r = 18'sd8192;
            1:       r = 18'sd4836;
            2:       r = 18'sd2555;
            3:       r = 18'sd1297;
            4:       r = 18'sd651;
            5:       r = 18'sd326;
            6:       r = 18'sd163;
            7:       r = 18'sd81;
            8:       r = 18'sd41;
            9:       r = 18'sd20;
            10:      r = 18'sd10;
            11:      r = 18'sd5;
            12:      r = 18'sd3;
            13:      r = 18'sd1;
            14:      r = 18'sd1;
            default: r = 18'sd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/ttm_ram.sv =====
// Generic single write port RAM with registered read.
`default_nettype none
module ttm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== src/ttm_front.sv =====
// Front end: configuration registers, frame offsets and item classification.
`default_nettype none
module ttm_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output      logic          o_s_tready,
    input  wire logic [47:0]   i_s_tdata,
    input  wire logic [1:0]    i_s_tuser,
    input  wire logic          i_cfg_valid,
    output      logic          o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    input  wire logic          i_full,
    output      logic          o_push,
    output      ttm_pkg::t_item o_item,
    output      ttm_pkg::t_cfg  o_cfg
);
    import ttm_pkg::*;

    logic [9:0]  r_centre_x, r_centre_y;
    logic [19:0] r_r2;
    logic [15:0] r_depth_gain, r_zoom_step, r_rot_step, r_zoom, r_rot;
    logic [11:0] r_angle_gain;
    logic        acc;
    logic [9:0]  px, py;

    assign o_s_tready  = !i_full;
    assign o_cfg_ready = 1'b1;
    assign acc = i_s_tvalid && o_s_tready;
    assign px  = i_s_tdata[9:0];
    assign py  = i_s_tdata[19:10];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x   <= 10'd512;
            r_centre_y   <= 10'd384;
            r_r2         <= 20'd10000;
            r_depth_gain <= 16'd16384;
            r_angle_gain <= 12'd640;
            r_zoom_step  <= 16'd655;
            r_rot_step   <= 16'd655;
            r_zoom       <= '0;
            r_rot        <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_CENTRE_X:      r_centre_x   <= i_cfg_data[9:0];
                    CFG_CENTRE_Y:      r_centre_y   <= i_cfg_data[9:0];
                    CFG_HOLE_RADIUS:   r_r2 <= i_cfg_data[9:0] * i_cfg_data[9:0];
                    CFG_DEPTH_GAIN:    r_depth_gain <= i_cfg_data;
                    CFG_ANGLE_GAIN:    r_angle_gain <= i_cfg_data[11:0];
                    CFG_ZOOM_STEP:     r_zoom_step  <= i_cfg_data;
                    CFG_ROTATION_STEP: r_rot_step   <= i_cfg_data;
                    default: ;
                endcase
            end
            // advance both offsets on a frame transaction
            if (acc && t_op'(i_s_tuser) == OP_FRAME) begin
                r_zoom <= r_zoom + r_zoom_step;
                r_rot  <= r_rot + r_rot_step;
            end
        end
    end

    always_comb begin
        o_push      = 1'b0;
        o_item.wr   = 1'b0;
        o_item.dx   = $signed({1'b0, px}) - $signed({1'b0, r_centre_x});
        o_item.dy   = $signed({1'b0, py}) - $signed({1'b0, r_centre_y});
        o_item.zoom = r_zoom;
        o_item.rot  = r_rot;
        o_item.tidx = i_s_tdata[35:20];
        o_item.tval = i_s_tdata[43:36];
        unique case (t_op'(i_s_tuser))
            OP_PIXEL: o_push = acc;
            OP_WRITE: begin
                o_push    = acc;
                o_item.wr = 1'b1;
            end
            default: o_push = 1'b0;
        endcase
    end

    assign o_cfg.r2         = r_r2;
    assign o_cfg.depth_gain = r_depth_gain;
    assign o_cfg.angle_gain = r_angle_gain;
endmodule
`default_nettype wire

// ===== src/ttm_fifo.sv =====
// Short queue between front end and datapath.
`default_nettype none
module ttm_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ttm_pkg::t_item i_item,
    output      logic           o_full,
    input  wire logic           i_pop,
    output      logic           o_empty,
    output      ttm_pkg::t_item o_head
);
    import ttm_pkg::*;
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item           r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [PW:0]     r_count;

    assign o_full  = r_count == (PW+1)'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ===== src/ttm_back.sv =====
// Datapath: distance, log, divide, CORDIC angle and texture lookup pipeline.
`default_nettype none
module ttm_back #(
    parameter int TEX_SIDE = 256
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire ttm_pkg::t_item i_head,
    output      logic           o_pop,
    input  wire ttm_pkg::t_cfg  i_cfg,
    input  wire logic           i_tready,
    output      logic           o_tvalid,
    output      logic [7:0]     o_colour,
    output      logic           o_hole
);
    import ttm_pkg::*;
    localparam int TW    = $clog2(TEX_SIDE);
    localparam int AW    = 2 * TW;
    localparam int S_SQ  = 2;
    localparam int S_LN  = S_SQ + NUM_SQ;
    localparam int S_DV  = S_LN + 1;
    localparam int NST   = S_DV + DIV_BITS;

    typedef struct packed {
        logic               vld;
        logic               wr;
        logic               hole;
        logic               tiny;
        logic               zero;
        logic [21:0]        d2;
        logic [4:0]         e;
        logic [30:0]        m;
        logic [15:0]        frac;
        logic [15:0]        lnv;
        logic [16:0]        rem;
        logic [24:0]        quo;
        logic signed [29:0] cx;
        logic signed [29:0] cy;
        logic signed [17:0] cz;
        logic signed [23:0] ang;
        logic signed [10:0] dx;
        logic signed [10:0] dy;
        logic [15:0]        zoom;
        logic [15:0]        rot;
        logic [15:0]        tidx;
        logic [7:0]         tval;
    } t_work;

    t_work r_st [NST];
    t_work n_st [NST];
    logic  en, r_ov, r_hole;
    logic [7:0] rdata;

    // whole pipeline moves when the output register is free or being drained
    assign en    = !r_ov || i_tready;
    assign o_pop = en && !i_empty;

    // squared distance and hole test
    always_comb begin
        logic signed [21:0] sx, sy;
        n_st[0]       = '0;
        n_st[0].vld   = !i_empty;
        n_st[0].wr    = i_head.wr;
        n_st[0].dx    = i_head.dx;
        n_st[0].dy    = i_head.dy;
        n_st[0].zoom  = i_head.zoom;
        n_st[0].rot   = i_head.rot;
        n_st[0].tidx  = i_head.tidx;
        n_st[0].tval  = i_head.tval;
        sx = i_head.dx * i_head.dx;
        sy = i_head.dy * i_head.dy;
        n_st[0].d2    = 22'(sx) + 22'(sy);
        n_st[0].hole  = n_st[0].d2 < 22'(i_cfg.r2);
        n_st[0].tiny  = n_st[0].d2 <= 22'd1;
        n_st[0].zero  = (i_head.dx == '0) && (i_head.dy == '0);
    end

    // normalise for the log, fold the angle into the right half plane
    always_comb begin
        n_st[1]   = r_st[0];
        n_st[1].e = '0;
        for (int b = 0; b < 22; b++) begin
            if (r_st[0].d2[b]) begin
                n_st[1].e = 5'(b);
            end
        end
        n_st[1].m    = 31'(r_st[0].d2) << (5'd30 - n_st[1].e);
        n_st[1].frac = '0;
        if (r_st[0].dy < 0) begin
            n_st[1].cx = -(30'(r_st[0].dy) <<< 16);
            n_st[1].cy = -(30'(r_st[0].dx) <<< 16);
            n_st[1].cz = (r_st[0].dx >= 0) ? HALF_TURN : -HALF_TURN;
        end else begin
            n_st[1].cx = 30'(r_st[0].dy) <<< 16;
            n_st[1].cy = 30'(r_st[0].dx) <<< 16;
            n_st[1].cz = '0;
        end
    end

    // one squaring step of the log and one CORDIC step per stage
    for (genvar i = 0; i < NUM_SQ; i++) begin : g_sq
        always_comb begin
            logic [61:0] p;
            logic [31:0] t;
            t_work w;
            w = r_st[S_SQ+i-1];
            p = {31'b0, w.m} * {31'b0, w.m};
            t = p[61:30];
            n_st[S_SQ+i] = w;
            n_st[S_SQ+i].m    = t[31] ? t[31:1] : t[30:0];
            n_st[S_SQ+i].frac = {w.frac[14:0], t[31]};
            if (!w.cy[29]) begin
                n_st[S_SQ+i].cx = w.cx + (w.cy >>> i);
                n_st[S_SQ+i].cy = w.cy - (w.cx >>> i);
                n_st[S_SQ+i].cz = w.cz + atan_unit(i);
            end else begin
                n_st[S_SQ+i].cx = w.cx - (w.cy >>> i);
                n_st[S_SQ+i].cy = w.cy + (w.cx >>> i);
                n_st[S_SQ+i].cz = w.cz - atan_unit(i);
            end
        end
    end

    // scale log2 to ln, scale angle by gain, seed the divider
    always_comb begin
        logic [36:0]        lp;
        logic signed [30:0] pr;
        t_work w;
        w  = r_st[S_LN-1];
        lp = 37'({w.e, w.frac}) * 37'(LN2_Q16);
        pr = $signed({1'b0, i_cfg.angle_gain}) * w.cz;
        n_st[S_LN]     = w;
        n_st[S_LN].lnv = lp[35:20];
        n_st[S_LN].ang = w.zero ? '0 : 24'(pr >>> 7);
        n_st[S_LN].rem = 17'(i_cfg.depth_gain[15:5]);
        n_st[S_LN].quo = '0;
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 0; j < DIV_BITS; j++) begin : g_dv
        logic nb;
        if (DIV_BITS-1-j >= 20) begin : g_hi
            assign nb = i_cfg.depth_gain[DIV_BITS-1-j-20];
        end else begin : g_lo
            assign nb = 1'b0;
        end
        always_comb begin
            logic [16:0] r2;
            t_work w;
            w  = r_st[S_DV+j-1];
            r2 = {w.rem[15:0], nb};
            n_st[S_DV+j] = w;
            if (r2 >= {1'b0, w.lnv}) begin
                n_st[S_DV+j].rem = r2 - {1'b0, w.lnv};
                n_st[S_DV+j].quo = {w.quo[23:0], 1'b1};
            end else begin
                n_st[S_DV+j].rem = r2;
                n_st[S_DV+j].quo = {w.quo[23:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_st[k].vld <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            for (int k = 0; k < NST; k++) begin
                r_st[k] <= n_st[k];
            end
            r_ov <= r_st[NST-1].vld && !r_st[NST-1].wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hole <= r_st[NST-1].hole;
        end
    end

    // texture address from the two wrapped coordinates
    logic [25:0]   us;
    logic [23:0]   vs;
    logic [TW-1:0] tu, tv;
    logic [AW-1:0] raddr;
    logic          we;
    assign us    = 26'(r_st[NST-1].tiny ? '0 : r_st[NST-1].quo) + 26'(r_st[NST-1].zoom);
    assign vs    = r_st[NST-1].ang + $signed({8'b0, r_st[NST-1].rot});
    assign tu    = us[8+TW-1:8];
    assign tv    = vs[8+TW-1:8];
    assign raddr = {tu, tv};
    assign we    = en && r_st[NST-1].vld && r_st[NST-1].wr &&
                   (32'(r_st[NST-1].tidx) < 32'(TEX_SIDE * TEX_SIDE));

    ttm_ram #(
        .WIDTH (8),
        .DEPTH (TEX_SIDE * TEX_SIDE)
    ) u_tex (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (AW'(r_st[NST-1].tidx)),
        .i_wdata (r_st[NST-1].tval),
        .i_re    (en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_tvalid = r_ov;
    assign o_hole   = r_hole;
    assign o_colour = r_hole ? 8'd0 : rdata;
endmodule
`default_nettype wire

// ===== src/tunnel_texture_mapper_unit.sv =====
// Top level of the tunnel texture mapper: front end, queue and datapath.
// Pipeline: a pixel transaction passes through 44 datapath stages, the first loaded
// from the queue, and then through the texture read register.
// Throughput: one item per cycle; the output register stalls the whole datapath.
// Reset (synchronous, active low) clears pipeline valids, the queue, frame offsets
// and loads register defaults; the texture store is left unwritten.
`default_nettype none
module tunnel_texture_mapper_unit #(
    parameter int TEX_SIDE   = 256,
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream, tdata from bit 0: pixel_x[10], pixel_y[10],
    // texel_index[16], texel_value[8], zero pad[4]
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [47:0] i_s_tdata,
    input  wire logic [1:0]  i_s_tuser,   // operation
    // master stream
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [7:0]  o_m_tdata,   // colour
    output      logic        o_m_tuser,   // in_hole
    // register write channel
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import ttm_pkg::*;

    t_item item, head;
    t_cfg  cfg;
    logic  push, full, pop, empty;

    // accept and classify; frame transactions end here
    ttm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_item      (item),
        .o_cfg       (cfg)
    );

    // decouple intake from datapath stalls
    ttm_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    // texel writes travel the same pipeline so they stay ordered with reads
    ttm_back #(
        .TEX_SIDE (TEX_SIDE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .i_cfg    (cfg),
        .i_tready (i_m_tready),
        .o_tvalid (o_m_tvalid),
        .o_colour (o_m_tdata),
        .o_hole   (o_m_tuser)
    );
endmodule
`default_nettype wire

// ===== src/ttm_checker.sv =====
// Port-level checks of the tunnel texture mapper, bound to the top level.
`default_nettype none
module ttm_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic       o_m_tuser
);
    // a hole pixel is always colour zero
    a_hole_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 8'd0))
        else $error("hole pixel with nonzero colour");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("stalled result changed");
endmodule

bind tunnel_texture_mapper_unit ttm_checker u_ttm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
